>>> rtl/attitude_corrected_sky_projection_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of the sky projection block.
// ---------------------------------------------------------------------------
`ifndef ATTITUDE_CORRECTED_SKY_PROJECTION_DEFINES_SVH
`define ATTITUDE_CORRECTED_SKY_PROJECTION_DEFINES_SVH

// Same-cycle implication on the rising clock edge.
`define ACSP_ASSERT_IMPL(label, clock, ante, cons) \
  label: assert property (@(posedge clock) (ante) |-> (cons)) \
    else $error("sky projection check failed");

// Next-cycle implication on the rising clock edge.
`define ACSP_ASSERT_NEXT(label, clock, ante, cons) \
  label: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error("sky projection check failed");

`endif

>>> rtl/acsp_pkg.sv
// ---------------------------------------------------------------------------
// acsp_pkg
// Constants, types and the quarter-wave sine table of the sky projection.
// ---------------------------------------------------------------------------
package acsp_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int QUARTER_TURN     = 5760;
  localparam int HALF_QUARTER     = QUARTER_TURN / 2;
  localparam int FULL_TURN        = 4 * QUARTER_TURN;
  localparam int ZENITH_SQ        = 11;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint Q30_ONE      = longint'(1) << 30;
  localparam longint Q15_ONE      = longint'(1) << 15;
  localparam longint Q15_HALF     = longint'(1) << 14;

  // Table index = (r*DEPTH + QUARTER/2) / QUARTER, done as a reciprocal multiply.
  localparam int IDX_NW    = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + HALF_QUARTER + 1);
  localparam int IDX_LW    = $clog2(QUARTER_TURN);
  localparam int IDX_SHIFT = IDX_NW + IDX_LW;
  localparam int IDX_MW    = IDX_NW + 2;
  localparam int IDX_PW    = IDX_NW + IDX_MW;
  localparam longint IDX_MUL =
    ((longint'(1) << IDX_SHIFT) + QUARTER_TURN - 1) / QUARTER_TURN;
  localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIN_W     = 15;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DOME_RADIUS   = 3'd2,
    REG_CENTER_X      = 3'd3,
    REG_CENTER_Y      = 3'd4
  } cfg_reg_t;

  typedef logic [SIN_W-1:0] sin_rom_t [0:SINE_TABLE_DEPTH];

  // Entry k is sin(k * 90deg / DEPTH) from a 9-term Taylor series in Q30,
  // rounded half up to Q15 and capped at the largest positive value.
  // Each term is the previous one times -x^2, divided by (2n)(2n+1).
  function automatic sin_rom_t build_sin_rom();
    sin_rom_t tab;
    longint x, x2, term, sum, v;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) / Q30_ONE;
      term = x;
      sum  = x;
      term = -(((term * x2) / Q30_ONE) / 64'sd6);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd20);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd42);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd72);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd110);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd156);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd210);
      sum  = sum + term;
      term = -(((term * x2) / Q30_ONE) / 64'sd272);
      sum  = sum + term;
      if (sum < 0) sum = 0;
      v = (sum + Q15_HALF) / Q15_ONE;
      if (v > 32767) v = 32767;
      tab[k] = SIN_W'(v);
    end
    return tab;
  endfunction

endpackage

>>> rtl/acsp_trig.sv
// ---------------------------------------------------------------------------
// acsp_trig
// Five-stage sine and cosine of one angle in 1/64 degree, Q1.15 results.
// ---------------------------------------------------------------------------
module acsp_trig (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] ang,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  typedef struct packed {
    logic [12:0] r;
    logic        neg;
  } quad_t;

  localparam acsp_pkg::sin_rom_t ROM = acsp_pkg::build_sin_rom();

  // Wrap to one turn, then fold the quadrant onto the first quarter.
  function automatic quad_t reduce(input logic signed [17:0] b);
    logic signed [17:0] m;
    quad_t res;
    if (b < 0) begin
      m = b + 18'(acsp_pkg::FULL_TURN);
    end else if (b >= 18'(acsp_pkg::FULL_TURN)) begin
      m = b - 18'(acsp_pkg::FULL_TURN);
    end else begin
      m = b;
    end
    if (m < 18'(acsp_pkg::QUARTER_TURN)) begin
      res.r   = 13'(m);
      res.neg = 1'b0;
    end else if (m < 18'(2 * acsp_pkg::QUARTER_TURN)) begin
      res.r   = 13'(18'(2 * acsp_pkg::QUARTER_TURN) - m);
      res.neg = 1'b0;
    end else if (m < 18'(3 * acsp_pkg::QUARTER_TURN)) begin
      res.r   = 13'(m - 18'(2 * acsp_pkg::QUARTER_TURN));
      res.neg = 1'b1;
    end else begin
      res.r   = 13'(18'(acsp_pkg::FULL_TURN) - m);
      res.neg = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [acsp_pkg::IDX_W-1:0] to_idx(
    input logic [acsp_pkg::IDX_NW-1:0] n
  );
    logic [acsp_pkg::IDX_PW-1:0] p;
    p = acsp_pkg::IDX_PW'(n) * acsp_pkg::IDX_PW'(acsp_pkg::IDX_MUL);
    return acsp_pkg::IDX_W'(p >> acsp_pkg::IDX_SHIFT);
  endfunction

  quad_t s_q_r, c_q_r;
  logic [acsp_pkg::IDX_NW-1:0] s_n_r, c_n_r;
  logic [acsp_pkg::IDX_W-1:0]  s_idx_r, c_idx_r;
  logic [acsp_pkg::SIN_W-1:0]  s_rom_r, c_rom_r;
  logic [2:0] s_neg_r, c_neg_r;
  logic signed [15:0] sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_q_r   <= reduce(18'(ang));
      c_q_r   <= reduce(18'(ang) + 18'(acsp_pkg::QUARTER_TURN));
      s_n_r   <= acsp_pkg::IDX_NW'(s_q_r.r) * acsp_pkg::IDX_NW'(acsp_pkg::SINE_TABLE_DEPTH)
                 + acsp_pkg::IDX_NW'(acsp_pkg::HALF_QUARTER);
      c_n_r   <= acsp_pkg::IDX_NW'(c_q_r.r) * acsp_pkg::IDX_NW'(acsp_pkg::SINE_TABLE_DEPTH)
                 + acsp_pkg::IDX_NW'(acsp_pkg::HALF_QUARTER);
      s_idx_r <= to_idx(s_n_r);
      c_idx_r <= to_idx(c_n_r);
      s_rom_r <= ROM[s_idx_r];
      c_rom_r <= ROM[c_idx_r];
      s_neg_r <= {s_neg_r[1:0], s_q_r.neg};
      c_neg_r <= {c_neg_r[1:0], c_q_r.neg};
      sin_r   <= s_neg_r[2] ? -$signed({1'b0, s_rom_r}) : $signed({1'b0, s_rom_r});
      cos_r   <= c_neg_r[2] ? -$signed({1'b0, c_rom_r}) : $signed({1'b0, c_rom_r});
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> rtl/attitude_corrected_sky_projection.sv
// ---------------------------------------------------------------------------
// attitude_corrected_sky_projection
// Rotates a sky direction by roll, pitch and yaw and projects it to screen.
// ---------------------------------------------------------------------------
// The input channel takes one word per cycle: azimuth, altitude and the three
// attitude angles, all in 1/64 degree. The output channel returns one word per
// input: clamped screen x and y, and a flag set when the direction lies so
// close to the zenith that the screen center is returned.
// Accepted words pass through the angle reduction, table index multiply, table
// read and sign stages, then through the vector, the three rotations, the
// projection products and the final add and clamp to the output register.
// Throughput is one word per cycle while the receiver does not stall.
// The configuration port writes screen size, dome radius and center; writes
// must only be made while no word is in flight.
// Reset clears the valid bits of every stage and loads the default screen
// setup. When the receiver stalls, the whole pipeline holds and in_ready
// drops only while a finished word waits on the output.
// ---------------------------------------------------------------------------
module attitude_corrected_sky_projection (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [14:0]        in_azimuth,
  input  logic signed [13:0] in_altitude,
  input  logic signed [14:0] in_roll_angle,
  input  logic signed [14:0] in_pitch_angle,
  input  logic signed [14:0] in_yaw_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_screen_x,
  output logic [9:0]         out_screen_y,
  output logic               out_at_zenith,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [11:0]        cfg_wdata
);

  localparam int LAT = 11;

  function automatic logic signed [19:0] rnd(input logic signed [37:0] p);
    logic signed [37:0] t;
    t = p + 38'sd16384;
    return 20'(t >>> 15);
  endfunction

  function automatic logic signed [14:0] trunc15(input logic signed [29:0] p);
    logic signed [29:0] t;
    t = (p < 0) ? p + 30'sd32767 : p;
    return 15'(t >>> 15);
  endfunction

  function automatic logic [9:0] clamp(input logic signed [15:0] v,
                                       input logic [10:0] size);
    logic [10:0] lim;
    if (size == 11'd0) begin
      lim = 11'd1;
    end else if (size > 11'd1024) begin
      lim = 11'd1024;
    end else begin
      lim = size;
    end
    if (v < 0) begin
      return 10'd0;
    end else if (v >= $signed({5'd0, lim})) begin
      return 10'(lim - 11'd1);
    end else begin
      return 10'(v);
    end
  endfunction

  logic [10:0] width_r, height_r;
  logic [9:0]  radius_r;
  logic signed [11:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd240;
      height_r <= 11'd240;
      radius_r <= 10'd110;
      cx_r     <= 12'sd120;
      cy_r     <= 12'sd120;
    end else if (cfg_we) begin
      case (cfg_addr)
        acsp_pkg::REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[10:0];
        acsp_pkg::REG_SCREEN_HEIGHT: height_r <= cfg_wdata[10:0];
        acsp_pkg::REG_DOME_RADIUS:   radius_r <= cfg_wdata[9:0];
        acsp_pkg::REG_CENTER_X:      cx_r     <= $signed(cfg_wdata);
        acsp_pkg::REG_CENTER_Y:      cy_r     <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  logic signed [15:0] s_az, c_az, s_alt, c_alt, s_rl, c_rl, s_pt, c_pt, s_yw, c_yw;

  acsp_trig u_az (.clk(clk), .en(en), .ang($signed({2'b00, in_azimuth})),
                  .sin_o(s_az), .cos_o(c_az));
  acsp_trig u_alt (.clk(clk), .en(en), .ang(17'(in_altitude)),
                   .sin_o(s_alt), .cos_o(c_alt));
  acsp_trig u_roll (.clk(clk), .en(en), .ang(17'(in_roll_angle)),
                    .sin_o(s_rl), .cos_o(c_rl));
  acsp_trig u_pitch (.clk(clk), .en(en), .ang(17'(in_pitch_angle)),
                     .sin_o(s_pt), .cos_o(c_pt));
  acsp_trig u_yaw (.clk(clk), .en(en), .ang(17'(in_yaw_angle)),
                   .sin_o(s_yw), .cos_o(c_yw));

  logic signed [19:0] vx_r, vy_r, vz_r, rx_r, rz_r, vy2_r, ry_r, rx3_r, bx_r, by_r;
  logic signed [15:0] cr_r, sr_r;
  logic signed [15:0] cp_r [0:1];
  logic signed [15:0] sp_r [0:1];
  logic signed [15:0] cyw_r [0:2];
  logic signed [15:0] syw_r [0:2];
  logic signed [39:0] xx_r, yy_r;
  logic signed [14:0] tx_r, ty_r;
  logic [9:0] sx_r, sy_r;
  logic       zen_r;

  logic signed [10:0] rad_s;
  logic signed [40:0] mag;
  logic signed [15:0] px, py;

  assign rad_s = $signed({1'b0, radius_r});
  assign mag   = 41'(xx_r) + 41'(yy_r);
  assign px    = 16'(tx_r) + 16'(cx_r);
  assign py    = 16'(ty_r) + 16'(cy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // Unit vector of the sky direction.
      vx_r <= rnd(38'(c_alt) * 38'(s_az));
      vy_r <= rnd(38'(c_alt) * 38'(c_az));
      vz_r <= 20'(s_alt);
      cr_r <= c_rl;
      sr_r <= s_rl;
      cp_r[0] <= c_pt;  cp_r[1] <= cp_r[0];
      sp_r[0] <= s_pt;  sp_r[1] <= sp_r[0];
      cyw_r[0] <= c_yw; cyw_r[1] <= cyw_r[0]; cyw_r[2] <= cyw_r[1];
      syw_r[0] <= s_yw; syw_r[1] <= syw_r[0]; syw_r[2] <= syw_r[1];
      // Roll.
      rx_r  <= rnd(38'(vx_r) * 38'(cr_r) + 38'(vz_r) * 38'(sr_r));
      rz_r  <= rnd(38'(vz_r) * 38'(cr_r) - 38'(vx_r) * 38'(sr_r));
      vy2_r <= vy_r;
      // Pitch.
      ry_r  <= rnd(38'(vy2_r) * 38'(cp_r[1]) + 38'(rz_r) * 38'(sp_r[1]));
      rx3_r <= rx_r;
      // Yaw.
      bx_r <= rnd(38'(rx3_r) * 38'(cyw_r[2]) - 38'(ry_r) * 38'(syw_r[2]));
      by_r <= rnd(38'(rx3_r) * 38'(syw_r[2]) + 38'(ry_r) * 38'(cyw_r[2]));
      // Projection products; y points north, so its product is negated.
      xx_r <= 40'(bx_r) * 40'(bx_r);
      yy_r <= 40'(by_r) * 40'(by_r);
      tx_r <= trunc15(30'(rad_s) * 30'(bx_r));
      ty_r <= trunc15(-(30'(rad_s) * 30'(by_r)));
      // Near the zenith the center is shown instead.
      if (mag < 41'(acsp_pkg::ZENITH_SQ)) begin
        sx_r  <= clamp(16'(cx_r), width_r);
        sy_r  <= clamp(16'(cy_r), height_r);
        zen_r <= 1'b1;
      end else begin
        sx_r  <= clamp(px, width_r);
        sy_r  <= clamp(py, height_r);
        zen_r <= 1'b0;
      end
    end
  end

  assign out_valid     = vld_r[LAT-1];
  assign out_screen_x  = sx_r;
  assign out_screen_y  = sy_r;
  assign out_at_zenith = zen_r;

endmodule

>>> rtl/acsp_checker.sv
// ---------------------------------------------------------------------------
// acsp_checker
// Port-level checks of the sky projection block, bound to its top level.
// ---------------------------------------------------------------------------
`include "attitude_corrected_sky_projection_defines.svh"

module acsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [9:0]         out_screen_x,
  input logic [9:0]         out_screen_y,
  input logic               out_at_zenith
);

  // The pipeline moves exactly when the output word is free or being taken.
  `ACSP_ASSERT_IMPL(a_ready_follows_out, clk, rst_n, in_ready == (!out_valid || out_ready))

  `ACSP_ASSERT_NEXT(a_reset_empties, clk, !rst_n, !out_valid)

  `ACSP_ASSERT_NEXT(a_out_holds, clk, rst_n && out_valid && !out_ready, !rst_n || out_valid)

  `ACSP_ASSERT_NEXT(a_word_stable, clk, rst_n && out_valid && !out_ready, !rst_n || ($stable(out_screen_x) && $stable(out_screen_y) && $stable(out_at_zenith)))

endmodule

bind attitude_corrected_sky_projection acsp_checker u_acsp_checker (.*);

>>> tb/sv/attitude_corrected_sky_projection_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// attitude_corrected_sky_projection_tb
// Self-checking bench for the rotated sky projection.
// ---------------------------------------------------------------------------
// A queue of direction words is driven through a valid/ready driver with
// random gaps. The monitor compares each result word against a predictor
// that rebuilds the sine table, rotates the vector and projects it in fixed
// point. The screen setup is changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module attitude_corrected_sky_projection_tb;

  typedef struct {
    logic [14:0]        az;
    logic signed [13:0] alt;
    logic signed [14:0] roll;
    logic signed [14:0] pitch;
    logic signed [14:0] yaw;
  } direction_t;

  typedef struct {
    logic [9:0] sx;
    logic [9:0] sy;
    logic       zen;
  } screen_point_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [14:0] in_azimuth;
  logic signed [13:0] in_altitude;
  logic signed [14:0] in_roll_angle, in_pitch_angle, in_yaw_angle;
  logic [9:0] out_screen_x, out_screen_y;
  logic out_at_zenith;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [11:0] cfg_wdata;

  attitude_corrected_sky_projection uut (.*);

  direction_t    pending_dirs[$];
  screen_point_t expected_points[$];
  longint        sine_lut[0:acsp_pkg::SINE_TABLE_DEPTH];
  logic [10:0]   scr_w, scr_h;
  logic [9:0]    radius;
  logic [11:0]   cen_x, cen_y;
  int            fail_count = 0;
  int            idle_cycles = 0;
  int            in_gap = 0, out_gap = 0;
  bit            stall_free = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic void fill_sine_lut();
    longint x, x2, term, sum, v;
    for (int k = 0; k <= acsp_pkg::SINE_TABLE_DEPTH; k++) begin
      x = (acsp_pkg::HALF_PI_Q30 * longint'(k)) / acsp_pkg::SINE_TABLE_DEPTH;
      x2 = (x * x) / (longint'(1) << 30);
      term = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x2) / (longint'(1) << 30);
        term = -(term / longint'((2 * n) * (2 * n + 1)));
        sum += term;
      end
      if (sum < 0) sum = 0;
      v = (sum + 16384) / 32768;
      if (v > 32767) v = 32767;
      sine_lut[k] = v;
    end
  endfunction

  function automatic longint quarter_sine(longint r);
    longint idx;
    idx = (r * acsp_pkg::SINE_TABLE_DEPTH + acsp_pkg::QUARTER_TURN / 2)
          / acsp_pkg::QUARTER_TURN;
    if (idx < 0) idx = 0;
    if (idx > acsp_pkg::SINE_TABLE_DEPTH) idx = acsp_pkg::SINE_TABLE_DEPTH;
    return sine_lut[idx];
  endfunction

  function automatic longint sin_fix(longint a);
    longint m, r;
    m = a % acsp_pkg::FULL_TURN;
    if (m < 0) m += acsp_pkg::FULL_TURN;
    r = m % acsp_pkg::QUARTER_TURN;
    case (m / acsp_pkg::QUARTER_TURN)
      0: return quarter_sine(r);
      1: return quarter_sine(acsp_pkg::QUARTER_TURN - r);
      2: return -quarter_sine(r);
      default: return -quarter_sine(acsp_pkg::QUARTER_TURN - r);
    endcase
  endfunction

  function automatic longint cos_fix(longint a);
    return sin_fix(a + acsp_pkg::QUARTER_TURN);
  endfunction

  function automatic longint to_q15(longint p);
    p += 16384;
    if (p >= 0) return p / 32768;
    return -((-p + 32767) / 32768);
  endfunction

  function automatic logic [9:0] clamp_to(longint v, logic [10:0] size);
    longint lim;
    lim = size;
    if (lim < 1) lim = 1;
    if (lim > 1024) lim = 1024;
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return v[9:0];
  endfunction

  function automatic screen_point_t project_direction(direction_t d);
    screen_point_t p;
    longint ca, x, y, z, cr, sr, cp, sp, cy, sy, rx, rz, ry, vx, vy, cxs, cys, rr;
    cxs = longint'($signed(cen_x));
    cys = longint'($signed(cen_y));
    rr = radius;
    ca = cos_fix(d.alt);
    x = to_q15(ca * sin_fix(d.az));
    y = to_q15(ca * cos_fix(d.az));
    z = sin_fix(d.alt);
    cr = cos_fix(d.roll);  sr = sin_fix(d.roll);
    cp = cos_fix(d.pitch); sp = sin_fix(d.pitch);
    cy = cos_fix(d.yaw);   sy = sin_fix(d.yaw);
    rx = to_q15(x * cr + z * sr);
    rz = to_q15(z * cr - x * sr);
    ry = to_q15(y * cp + rz * sp);
    vx = to_q15(rx * cy - ry * sy);
    vy = to_q15(rx * sy + ry * cy);
    if (vx * vx + vy * vy < acsp_pkg::ZENITH_SQ) begin
      p.sx = clamp_to(cxs, scr_w);
      p.sy = clamp_to(cys, scr_h);
      p.zen = 1'b1;
    end else begin
      p.sx = clamp_to((rr * vx) / 32768 + cxs, scr_w);
      p.sy = clamp_to((-rr * vy) / 32768 + cys, scr_h);
      p.zen = 1'b0;
    end
    return p;
  endfunction

  function automatic int pick_gap();
    if (stall_free) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 32767) - 16384;
    if (r == 1)
      return ($urandom_range(0, 8) - 4) * acsp_pkg::QUARTER_TURN + $urandom_range(0, 2) - 1;
    return $urandom_range(0, 2 * 11520) - 11520;
  endfunction

  // Driver: a word is lowered during a random gap or when nothing else is queued.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_azimuth <= '0;
      in_altitude <= '0;
      in_roll_angle <= '0;
      in_pitch_angle <= '0;
      in_yaw_angle <= '0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_points.push_back(project_direction(pending_dirs.pop_front()));
        in_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0 || pending_dirs.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end else begin
          in_valid <= 1'b1;
          in_azimuth <= pending_dirs[0].az;
          in_altitude <= pending_dirs[0].alt;
          in_roll_angle <= pending_dirs[0].roll;
          in_pitch_angle <= pending_dirs[0].pitch;
          in_yaw_angle <= pending_dirs[0].yaw;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    screen_point_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_points.pop_front();
          if (out_screen_x !== want.sx) report_mismatch("screen_x", out_screen_x, want.sx);
          if (out_screen_y !== want.sy) report_mismatch("screen_y", out_screen_y, want.sy);
          if (out_at_zenith !== want.zen)
            report_mismatch("at_zenith", out_at_zenith, want.zen);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!stall_free) out_gap = pick_gap();
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input acsp_pkg::cfg_reg_t idx, input logic [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      acsp_pkg::REG_SCREEN_WIDTH:  scr_w = val[10:0];
      acsp_pkg::REG_SCREEN_HEIGHT: scr_h = val[10:0];
      acsp_pkg::REG_DOME_RADIUS:   radius = val[9:0];
      acsp_pkg::REG_CENTER_X:      cen_x = val;
      acsp_pkg::REG_CENTER_Y:      cen_y = val;
      default: ;
    endcase
  endtask

  task automatic add_dir(int az, int alt, int roll, int pitch, int yaw);
    direction_t d;
    d.az = 15'(az);
    d.alt = 14'(alt);
    d.roll = 15'(roll);
    d.pitch = 15'(pitch);
    d.yaw = 15'(yaw);
    pending_dirs.push_back(d);
  endtask

  task automatic drain();
    wait (pending_dirs.size() == 0 && !in_valid && expected_points.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        add_dir($urandom_range(0, 32767), $urandom_range(0, 16383) - 8192,
                $urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
                $urandom_range(0, 32767) - 16384);
      else
        add_dir($urandom_range(0, 23039), $urandom_range(0, 11520) - 5760,
                rand_angle(), rand_angle(), rand_angle());
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    fill_sine_lut();
    scr_w = 240; scr_h = 240; radius = 110; cen_x = 120; cen_y = 120;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: zenith, horizon points, wrapped and extreme angles.
    add_dir(0, 5760, 0, 0, 0);
    add_dir(0, -5760, 0, 0, 0);
    add_dir(0, 0, 0, 0, 0);
    add_dir(5760, 0, 0, 0, 0);
    add_dir(11520, 0, 0, 0, 0);
    add_dir(17280, 0, 0, 0, 0);
    add_dir(23039, 1, 0, 0, 0);
    add_dir(32767, 8191, 16383, -16384, 16383);
    add_dir(0, -8192, -16384, 16383, -16384);
    add_dir(0, 0, 5760, 0, 0);
    add_dir(0, 0, 0, 5760, 0);
    add_dir(0, 0, 0, 0, -5760);
    add_dir(1234, 5759, 0, 0, 0);
    add_dir(0, 0, 11520, -11520, 11520);
    add_dir(100, 2000, 0, -5760, 0);
    add_dir(21000, -3000, 3000, 700, -9000);
    drain();

    // Extremes of the screen setup, including zero and oversize screen sizes.
    write_reg(acsp_pkg::REG_SCREEN_WIDTH, 12'd0);
    write_reg(acsp_pkg::REG_SCREEN_HEIGHT, 12'd2047);
    write_reg(acsp_pkg::REG_DOME_RADIUS, 12'd1023);
    write_reg(acsp_pkg::REG_CENTER_X, 12'h800);
    write_reg(acsp_pkg::REG_CENTER_Y, 12'h7FF);
    write_reg(acsp_pkg::cfg_reg_t'(3'd7), 12'hABC);
    random_phase(150);

    write_reg(acsp_pkg::REG_SCREEN_WIDTH, 12'd1024);
    write_reg(acsp_pkg::REG_SCREEN_HEIGHT, 12'd1);
    write_reg(acsp_pkg::REG_DOME_RADIUS, 12'd0);
    write_reg(acsp_pkg::REG_CENTER_X, 12'd512);
    write_reg(acsp_pkg::REG_CENTER_Y, 12'hFFF);
    random_phase(150);

    write_reg(acsp_pkg::REG_SCREEN_WIDTH, 12'd1025);
    write_reg(acsp_pkg::REG_SCREEN_HEIGHT, 12'd1024);
    write_reg(acsp_pkg::REG_DOME_RADIUS, 12'd500);
    write_reg(acsp_pkg::REG_CENTER_X, 12'd512);
    write_reg(acsp_pkg::REG_CENTER_Y, 12'd512);
    random_phase(300);

    // No stalls on either side for one stretch.
    stall_free = 1;
    write_reg(acsp_pkg::REG_SCREEN_WIDTH, 12'd320);
    write_reg(acsp_pkg::REG_SCREEN_HEIGHT, 12'd200);
    write_reg(acsp_pkg::REG_DOME_RADIUS, 12'd90);
    write_reg(acsp_pkg::REG_CENTER_X, 12'd160);
    write_reg(acsp_pkg::REG_CENTER_Y, 12'd100);
    random_phase(150);
    stall_free = 0;
    random_phase(150);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/acsp_pkg.sv
rtl/acsp_trig.sv
rtl/attitude_corrected_sky_projection.sv
rtl/acsp_checker.sv
tb/sv/attitude_corrected_sky_projection_tb.sv
